### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("forbidden condition");

`else

`define ASSERT_PROP(label, clk, rst, prop)

`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

### rtl/crbg_pkg.sv
// ----------------------------------------------------------------------------
// crbg_pkg
// types and constants of the chunk receipt bitmap and gap scanner
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package crbg_pkg;

   localparam int TYPE_W  = 2;
   localparam int INDEX_W = 8;
   localparam int RANGE_W = 7;
   localparam int COUNT_W = 8;

   typedef enum logic [TYPE_W-1:0] {
      REQ_MARK  = 2'd0,
      REQ_EOF   = 2'd1,
      REQ_SCAN  = 2'd2,
      REQ_CLEAR = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic [TYPE_W-1:0]  req_type;
      logic [INDEX_W-1:0] chunk_no;
   } req_item_type;

   typedef struct packed {
      logic               status;
      logic               range_valid;
      logic [RANGE_W-1:0] range_first;
      logic [RANGE_W-1:0] range_final;
      logic               last;
      logic               eof_seen;
   } rsp_item_type;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_WALK   = 3'b010,
      S_FINISH = 3'b100
   } scan_state_type;

   typedef struct packed {
      logic busy;
      logic emit;
   } scan_stat_type;

endpackage

`default_nettype wire

### rtl/chunk_receipt_bitmap_gap_ranges.sv
// Mark and eof items: result registered at the accepting edge, one item per cycle while
// the result side keeps up and no scan or clearing pass runs. Clear items likewise, then
// a clearing pass over the bitmap. Scan items keep the input stalled while the scanner
// walks the effective chunk count, one bitmap bit read per cycle while results are taken,
// then offers any open run and the last result. Synchronous reset clears the eof flag
// and chunk count at once, then runs the clearing pass with the input stalled.
// ----------------------------------------------------------------------------
// chunk_receipt_bitmap_gap_ranges
// chunk receipt bitmap with eof flag and missing-run scan
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module chunk_receipt_bitmap_gap_ranges #(
   parameter int MAX_CHUNKS = 128
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire crbg_pkg::req_item_type            req_item,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output crbg_pkg::rsp_item_type                 rsp_item,
   input  wire logic                              csr_write_en,
   input  wire logic [crbg_pkg::COUNT_W-1:0]      csr_write_data
);

   import crbg_pkg::*;

   localparam int IW = $clog2(MAX_CHUNKS + 1);
   localparam int AW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

   logic [COUNT_W-1:0] chunk_count_ff;
   logic               eof_ff, eof_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_item_ff, rsp_item_in;

   logic [IW-1:0]      n_cnt;
   logic               slot_free;
   logic               req_accept;
   logic               is_scan;
   logic               in_range;
   logic               set_en;
   logic               clear_en;
   logic               single_load;
   logic               rd_bit;
   logic [AW-1:0]      rd_addr;
   logic               wipe_busy;
   logic               rsp_range_ok;
   scan_stat_type      scan_stat;
   rsp_item_type       scan_rsp;
   rsp_item_type       single_rsp;

   assign n_cnt = (chunk_count_ff > COUNT_W'(MAX_CHUNKS)) ? IW'(MAX_CHUNKS)
                                                           : IW'(chunk_count_ff);

   assign slot_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = scan_stat.busy || wipe_busy || !slot_free;
   assign req_accept  = req_valid && !req_stall;
   assign is_scan     = (req_item.req_type == REQ_SCAN);
   assign in_range    = (req_item.chunk_no < COUNT_W'(n_cnt));
   assign set_en      = req_accept && (req_item.req_type == REQ_MARK) && in_range;
   assign clear_en    = req_accept && (req_item.req_type == REQ_CLEAR);
   assign single_load = req_accept && !is_scan;

   always_comb begin
      eof_in = eof_ff;
      if (req_accept && (req_item.req_type == REQ_EOF)) begin
         eof_in = 1'b1;
      end else if (clear_en) begin
         eof_in = 1'b0;
      end
   end

   always_comb begin
      single_rsp          = '0;
      single_rsp.status   = (req_item.req_type == REQ_MARK) && !in_range;
      single_rsp.last     = 1'b1;
      single_rsp.eof_seen = eof_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (single_load) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = single_rsp;
      end else if (scan_stat.emit && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = scan_rsp;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_count_ff <= '0;
         eof_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_en) begin
            chunk_count_ff <= csr_write_data;
         end
         eof_ff       <= eof_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   crbg_bitmap #(
      .DEPTH (MAX_CHUNKS),
      .AW    (AW)
   ) u_bitmap (
      .clock     (clock),
      .reset     (reset),
      .set_en    (set_en),
      .set_addr  (req_item.chunk_no[AW-1:0]),
      .clear_en  (clear_en),
      .rd_addr   (rd_addr),
      .rd_bit    (rd_bit),
      .wipe_busy (wipe_busy)
   );

   crbg_scan #(
      .IW (IW),
      .AW (AW)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .start     (req_accept && is_scan),
      .slot_free (slot_free),
      .n_cnt     (n_cnt),
      .eof_in    (eof_ff),
      .rd_bit    (rd_bit),
      .rd_addr   (rd_addr),
      .stat      (scan_stat),
      .rsp       (scan_rsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign rsp_range_ok = !rsp_item_ff.status &&
                         (rsp_item_ff.range_first <= rsp_item_ff.range_final);

   `ASSERT_PROP(a_single_result, clock, reset, single_load |=> (rsp_valid_ff && rsp_item_ff.last))
   `ASSERT_PROP(a_clear_eof, clock, reset, clear_en |=> !eof_ff)
   `ASSERT_PROP(a_range_ok, clock, reset, (rsp_valid_ff && rsp_item_ff.range_valid) |-> rsp_range_ok)

endmodule

`default_nettype wire

### rtl/crbg_bitmap.sv
// ----------------------------------------------------------------------------
// crbg_bitmap
// one received bit per chunk, set by marks, wiped entry by entry after reset
// or clear, read with registered data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crbg_bitmap #(
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          set_en,
   input  wire logic [AW-1:0] set_addr,
   input  wire logic          clear_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic               rd_bit,
   output logic               wipe_busy
);

   logic          mem [DEPTH];
   logic          rd_bit_ff;
   logic          wipe_ff, wipe_in;
   logic [AW-1:0] wipe_addr_ff, wipe_addr_in;
   logic          wipe_last;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic          wr_data;

   assign wipe_last = (wipe_addr_ff == AW'(DEPTH - 1));

   always_comb begin
      wipe_in      = wipe_ff;
      wipe_addr_in = wipe_addr_ff;
      if (clear_en) begin
         wipe_in      = 1'b1;
         wipe_addr_in = '0;
      end else if (wipe_ff) begin
         wipe_addr_in = wipe_addr_ff + AW'(1);
         if (wipe_last) begin
            wipe_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wipe_ff      <= 1'b1;
         wipe_addr_ff <= '0;
      end else begin
         wipe_ff      <= wipe_in;
         wipe_addr_ff <= wipe_addr_in;
      end
   end

   assign wr_en   = wipe_ff || set_en;
   assign wr_addr = wipe_ff ? wipe_addr_ff : set_addr;
   assign wr_data = !wipe_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_bit_ff <= mem[rd_addr];
   end

   assign rd_bit    = rd_bit_ff;
   assign wipe_busy = wipe_ff;

endmodule

`default_nettype wire

### rtl/crbg_scan.sv
// ----------------------------------------------------------------------------
// crbg_scan
// walks the bitmap one chunk a cycle while results are taken, offers each missing run, then a last result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module crbg_scan #(
   parameter int IW = 8,
   parameter int AW = 7
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  slot_free,
   input  wire logic [IW-1:0]         n_cnt,
   input  wire logic                  eof_in,
   input  wire logic                  rd_bit,
   output logic [AW-1:0]              rd_addr,
   output crbg_pkg::scan_stat_type    stat,
   output crbg_pkg::rsp_item_type     rsp
);

   import crbg_pkg::*;

   scan_state_type     state_ff, state_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic               open_ff, open_in;
   logic [RANGE_W-1:0] start_ff, start_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [RANGE_W-1:0] pend_first_ff, pend_first_in;
   logic [RANGE_W-1:0] pend_final_ff, pend_final_in;
   logic               missing;
   logic               at_end;
   logic               closing;
   logic               emit;
   logic               last_flag;
   logic [RANGE_W-1:0] run_final;

   // read the bit of the next index so that it lands with idx_ff
   assign rd_addr   = idx_in[AW-1:0];
   assign missing   = !rd_bit;
   assign at_end    = (idx_ff == n_cnt);
   assign closing   = open_ff && !missing;
   assign run_final = RANGE_W'(idx_ff - IW'(1));

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      open_in       = open_ff;
      start_in      = start_ff;
      pend_valid_in = pend_valid_ff;
      pend_first_in = pend_first_ff;
      pend_final_in = pend_final_ff;
      emit          = 1'b0;
      last_flag     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in      = S_WALK;
               idx_in        = '0;
               open_in       = 1'b0;
               pend_valid_in = 1'b0;
            end
         end
         S_WALK: begin
            if (at_end) begin
               state_in = S_FINISH;
            end else if (!(closing && pend_valid_ff && !slot_free)) begin
               idx_in = idx_ff + IW'(1);
               if (missing && !open_ff) begin
                  open_in  = 1'b1;
                  start_in = RANGE_W'(idx_ff);
               end else if (closing) begin
                  emit          = pend_valid_ff;
                  open_in       = 1'b0;
                  pend_valid_in = 1'b1;
                  pend_first_in = start_ff;
                  pend_final_in = run_final;
               end
            end
         end
         S_FINISH: begin
            if (open_ff) begin
               if (!(pend_valid_ff && !slot_free)) begin
                  emit          = pend_valid_ff;
                  open_in       = 1'b0;
                  pend_valid_in = 1'b1;
                  pend_first_in = start_ff;
                  pend_final_in = run_final;
               end
            end else begin
               emit      = 1'b1;
               last_flag = 1'b1;
               if (slot_free) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         open_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         idx_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         open_ff       <= open_in;
         pend_valid_ff <= pend_valid_in;
         idx_ff        <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff      <= start_in;
      pend_first_ff <= pend_first_in;
      pend_final_ff <= pend_final_in;
   end

   assign stat.busy = (state_ff != S_IDLE);
   assign stat.emit = emit;

   always_comb begin
      rsp             = '0;
      rsp.range_valid = pend_valid_ff;
      rsp.range_first = pend_valid_ff ? pend_first_ff : '0;
      rsp.range_final = pend_valid_ff ? pend_final_ff : '0;
      rsp.last        = last_flag;
      rsp.eof_seen    = eof_in;
   end

   `ASSERT_PROP(a_emit_busy, clock, reset, stat.emit |-> stat.busy)
   `ASSERT_PROP(a_idx_bound, clock, reset, stat.busy |-> (idx_ff <= n_cnt))
   `ASSERT_PROP(a_pend_order, clock, reset, pend_valid_ff |-> (pend_first_ff <= pend_final_ff))

endmodule

`default_nettype wire
